/* design/multi_mode_lehmer_rng_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Lehmer generator unit
// Clocked implication checks shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_LEHMER_RNG_UNIT_MACROS_SVH
`define MULTI_MODE_LEHMER_RNG_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lmr_pkg.sv */
// ----------------------------------------------------------------------------
// lmr_pkg
// Constants, mode codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lmr_pkg;

	localparam int unsigned SeedW = 31;
	localparam int unsigned MultW = 17;
	localparam int unsigned ProdW = SeedW + MultW;

	// Park-Miller modulus 2^31-1 and the L'Ecuyer modulus 2^31-249.
	localparam logic [SeedW-1:0] PM_MOD     = 31'h7FFF_FFFF;
	localparam logic [SeedW-1:0] LE_MOD     = 31'd2147483399;
	localparam logic [7:0]       LE_FOLD    = 8'd249;
	localparam logic [SeedW-1:0] RESET_SEED = 31'd123456;

	localparam logic [MultW-1:0] MUL_READ  = 17'd48271;
	localparam logic [MultW-1:0] MUL_MOVE  = 17'd16807;
	localparam logic [MultW-1:0] MUL_REACT = 17'd69621;
	localparam logic [MultW-1:0] MUL_PROD  = 17'd40692;

	localparam logic [2:0] MODE_READ      = 3'd0;
	localparam logic [2:0] MODE_MOVE      = 3'd1;
	localparam logic [2:0] MODE_REACT     = 3'd2;
	localparam logic [2:0] MODE_PRODUCT   = 3'd3;
	localparam logic [2:0] MODE_GILLESPIE = 3'd4;

	typedef struct packed {
		logic load;
		logic sum;
		logic mul;
		logic reduce;
	} lmr_cmd_t;

	typedef struct packed {
		logic in_react;
	} lmr_sts_t;

	// Multiplier per mode; undefined modes multiply by zero so they give zero.
	function automatic logic [MultW-1:0] mult_for_mode(input logic [2:0] m);
		logic [MultW-1:0] k;
		unique case (m)
			MODE_READ:      k = MUL_READ;
			MODE_MOVE:      k = MUL_MOVE;
			MODE_REACT:     k = MUL_REACT;
			MODE_PRODUCT:   k = MUL_PROD;
			MODE_GILLESPIE: k = MUL_MOVE;
			default:        k = '0;
		endcase
		return k;
	endfunction

endpackage

/* design/multi_mode_lehmer_rng_unit.sv */
// ----------------------------------------------------------------------------
// multi_mode_lehmer_rng_unit
// Five-mode Lehmer generator: steps a stored or supplied 31-bit seed by a
// mode constant and reduces it exactly modulo 2^31-1 or 2147483399.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                Payload
//   -------   ----------------------   -------------------------
//   input     in_valid / in_ready      mode, seed_a, seed_b
//   output    out_valid / out_ready    new_seed, fraction
//   config    cfg_wr_en                cfg_wr_data (start seed)
//
// A word passes from acceptance to result through load, multiply and reduce
// steps, with a sum step before the multiply in react mode, where the two
// reactant seeds are first summed and folded. The single 31x17 constant multiplier serves every mode.
// One word is in flight at a time; the result sits in an output register, and
// when it has not been taken the reduce step waits until the output frees up.
// Reset loads the internal seed with 123456; a configuration write reloads it.
//
// Read and gillespie modes step the internal seed (by 48271 and 16807) and
// store the result back. Move steps seed_a by 16807, react folds
// seed_a + seed_b modulo 2^31-1 and steps that by 69621, and product steps
// seed_a by 40692 modulo 2147483399; none of these touch the internal seed.
// Undefined mode codes leave the state alone and give zero. The fraction is
// the new seed read as an unsigned Q0.31 value, so both outputs carry the same
// bits.
// ----------------------------------------------------------------------------
module multi_mode_lehmer_rng_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [lmr_pkg::SeedW-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                mode,
	input  logic [lmr_pkg::SeedW-1:0] seed_a,
	input  logic [lmr_pkg::SeedW-1:0] seed_b,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [lmr_pkg::SeedW-1:0] new_seed,
	output logic [lmr_pkg::SeedW-1:0] fraction
);
	import lmr_pkg::*;

	lmr_cmd_t         cmd;
	lmr_sts_t         sts;
	logic [SeedW-1:0] result;

	// The controller only sequences; all arithmetic and the seed live in the datapath.
	lmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lmr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mode        (mode),
		.seed_a      (seed_a),
		.seed_b      (seed_b),
		.result      (result)
	);

	// The Q0.31 fraction is the seed itself; no scaling is applied.
	assign new_seed = result;
	assign fraction = result;

endmodule

/* design/lmr_dp.sv */
// ----------------------------------------------------------------------------
// lmr_dp
// Datapath: operand capture, reactant sum fold, constant multiply and
// modular reduction, internal seed and result registers.
// ----------------------------------------------------------------------------
`include "multi_mode_lehmer_rng_unit_macros.svh"

module lmr_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lmr_pkg::lmr_cmd_t        cmd,
	output lmr_pkg::lmr_sts_t        sts,
	input  logic                     cfg_wr_en,
	input  logic [lmr_pkg::SeedW-1:0] cfg_wr_data,
	input  logic [2:0]               mode,
	input  logic [lmr_pkg::SeedW-1:0] seed_a,
	input  logic [lmr_pkg::SeedW-1:0] seed_b,
	output logic [lmr_pkg::SeedW-1:0] result
);
	import lmr_pkg::*;

	logic [2:0]       mode_q;
	logic [SeedW-1:0] op_q;
	logic [SeedW-1:0] b_q;
	logic [ProdW-1:0] prod_q;
	logic [SeedW-1:0] result_q;
	logic [SeedW-1:0] internal_seed_q;

	logic [SeedW:0]   ab_sum;
	logic [SeedW:0]   ab_fold;
	logic [SeedW-1:0] ab_red;
	logic [ProdW-1:0] prod_next;
	logic [MultW-1:0] prod_hi;
	logic [SeedW-1:0] prod_lo;
	logic [24:0]      le_fold;
	logic [SeedW:0]   pm_sum;
	logic [SeedW:0]   le_sum;
	logic [SeedW:0]   sel_sum;
	logic [SeedW:0]   sel_mod;
	logic [SeedW:0]   red;
	logic             uses_internal;
	logic             writes_internal;

	assign sts.in_react = (mode == MODE_REACT);
	assign uses_internal = (mode == MODE_READ) || (mode == MODE_GILLESPIE);
	assign writes_internal = (mode_q == MODE_READ) || (mode_q == MODE_GILLESPIE);

	// Reactant sum: the carry out of bit 30 is worth one modulo 2^31-1.
	assign ab_sum  = {1'b0, op_q} + {1'b0, b_q};
	assign ab_fold = {1'b0, ab_sum[SeedW-1:0]} + {{SeedW{1'b0}}, ab_sum[SeedW]};
	assign ab_red  = (ab_fold >= {1'b0, PM_MOD}) ? SeedW'(ab_fold - {1'b0, PM_MOD})
	                                             : ab_fold[SeedW-1:0];

	assign prod_next = {{MultW{1'b0}}, op_q} * {{SeedW{1'b0}}, mult_for_mode(mode_q)};

	// Fold the high part back in: 2^31 is 1 modulo 2^31-1 and 249 modulo 2^31-249.
	// Either sum stays below twice the modulus, so one subtract finishes it.
	assign prod_hi = prod_q[ProdW-1:SeedW];
	assign prod_lo = prod_q[SeedW-1:0];
	assign le_fold = {8'b0, prod_hi} * {17'b0, LE_FOLD};
	assign pm_sum  = {1'b0, prod_lo} + {{(SeedW+1-MultW){1'b0}}, prod_hi};
	assign le_sum  = {1'b0, prod_lo} + {7'b0, le_fold};
	assign sel_sum = (mode_q == MODE_PRODUCT) ? le_sum : pm_sum;
	assign sel_mod = (mode_q == MODE_PRODUCT) ? {1'b0, LE_MOD} : {1'b0, PM_MOD};
	assign red     = (sel_sum >= sel_mod) ? (sel_sum - sel_mod) : sel_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			internal_seed_q <= RESET_SEED;
		end else if (cfg_wr_en) begin
			internal_seed_q <= cfg_wr_data;
		end else if (cmd.reduce && writes_internal) begin
			internal_seed_q <= red[SeedW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			op_q   <= uses_internal ? internal_seed_q : seed_a;
			b_q    <= seed_b;
		end
		if (cmd.sum) begin
			op_q <= ab_red;
		end
		if (cmd.mul) begin
			prod_q <= prod_next;
		end
		if (cmd.reduce) begin
			result_q <= red[SeedW-1:0];
		end
	end

	assign result = result_q;

	`LMR_ASSERT_NEXT(a_result_below_mod, clk, arst_n, cmd.reduce,
		result_q != PM_MOD, "reduced seed reached the modulus")
	`LMR_ASSERT_NEXT(a_undef_gives_zero, clk, arst_n,
		cmd.reduce && (mode_q > MODE_GILLESPIE), result_q == '0,
		"undefined mode gave a nonzero seed")
	`LMR_ASSERT_NEXT(a_product_below_mod, clk, arst_n,
		cmd.reduce && (mode_q == MODE_PRODUCT), result_q < LE_MOD,
		"product seed reached its modulus")

endmodule

/* design/lmr_ctrl.sv */
// ----------------------------------------------------------------------------
// lmr_ctrl
// Controller: sequences load, optional sum, multiply and reduce steps and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
`include "multi_mode_lehmer_rng_unit_macros.svh"

module lmr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  lmr_pkg::lmr_sts_t sts,
	output lmr_pkg::lmr_cmd_t cmd
);
	import lmr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_RED
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd.load   = accept;
		cmd.sum    = (state_q == ST_SUM);
		cmd.mul    = (state_q == ST_MUL);
		cmd.reduce = (state_q == ST_RED) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= sts.in_react ? ST_SUM : ST_MUL;
					end
				end
				ST_SUM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_RED;
				end
				ST_RED: begin
					if (cmd.reduce) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
			if (cmd.reduce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`LMR_ASSERT_SAME(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.sum, cmd.mul, cmd.reduce}), "more than one datapath step at once")
	`LMR_ASSERT_NEXT(a_react_sums, clk, arst_n, accept && sts.in_react, state_q == ST_SUM, "react word skipped the sum step")
	`LMR_ASSERT_NEXT(a_reduce_shows, clk, arst_n, cmd.reduce, out_valid_q, "reduced word not presented")
	`LMR_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.reduce, !out_valid_q || out_ready, "pending word overwritten")

endmodule
